// ===== rtl/core/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants for the allocation site profiler
// Payload structs, controller state, command and status bundles.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int unsigned SiteBits = 12;
  localparam int unsigned SiteCap  = 1 << SiteBits;
  localparam logic [63:0] HashMul  = 64'hff51afd7ed558ccd;
  localparam logic [31:0] PeakStepReset = 32'd1048576;

  typedef logic [SiteBits-1:0] site_idx_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_READ3 = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] return_addr;
    logic [31:0] block_size;
    logic [11:0] header_slot;
    logic        header_valid;
  } asp_in_t;

  typedef struct packed {
    logic [11:0] slot;
    logic [63:0] site_addr;
    logic [47:0] site_live_bytes;
    logic [31:0] site_live_count;
    logic [47:0] site_total_bytes;
    logic [31:0] site_total_count;
    logic [47:0] live_total;
    logic [47:0] peak_total;
    logic        dump_now;
    logic [31:0] dump_count;
    logic [31:0] collision_count;
    logic [31:0] foreign_count;
  } asp_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH1,
    ST_MUL,
    ST_HASH2,
    ST_READ,
    ST_UPDATE
  } asp_state_e;

  typedef struct packed {
    logic clear_step;   // write zero at the clear pointer, advance it
    logic load;         // capture the input request
    logic hash1;        // low and cross partial products
    logic mul;          // combine partial products into the hash product
    logic hash2;        // finish hash, issue table read
    logic rd;           // issue table read for free/read
    logic update;       // read-modify-write and build result
  } asp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_alloc;
  } asp_sts_t;

  function automatic logic [47:0] add48(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function automatic logic [47:0] sub48(logic [47:0] a, logic [31:0] b);
    return (a > {16'd0, b}) ? a - {16'd0, b} : 48'd0;
  endfunction

  function automatic logic [31:0] inc32(logic [31:0] a);
    return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
  endfunction

endpackage

// ===== rtl/core/alloc_site_profiler_core.sv =====
// Sequence: for an allocation, out_valid_o rises after the two multiply steps, slot
//   select, table read and update; for a free or read, after slot select, table read and update.
// A new request is accepted only in idle, once the previous one has reached update; a
//   waiting result holds only the update step, so output stall time adds to each request.
// Reset: after rst_ni releases, a clear pass writes all 4096 table entries;
//   in_stall_o stays high until the clear pass is done. peak_step resets to 1 MiB.
// ----------------------------------------------------------------------------
// alloc_site_profiler_core: per call-site heap allocation profiler
// Controller sequences each request; datapath owns the hash, site table
// memory and global counters.
// ----------------------------------------------------------------------------
module alloc_site_profiler_core import asp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  asp_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output asp_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  asp_cmd_t cmd;
  asp_sts_t sts;

  // Sequence: clear, accept, hash (allocation only), table read, update.
  asp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Result register holds the request's result until the sink takes it.
  asp_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .in_req_i            (in_data_i),
    .peak_step_wr_en_i   (cfg_we_i),
    .peak_step_wr_data_i (cfg_wdata_i),
    .out_rsp_o           (out_data_o)
  );

endmodule

// ===== rtl/core/asp_ctrl.sv =====
// ----------------------------------------------------------------------------
// asp_ctrl: sequencer for the allocation site profiler
// Runs the table clear after reset, then steps each request through its phases.
// ----------------------------------------------------------------------------
module asp_ctrl import asp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  asp_sts_t sts_i,
  output asp_cmd_t cmd_o
);

  asp_state_e state_q, state_d;
  logic       out_full_q, out_full_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

  assign out_valid_o = out_full_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    out_full_d = out_full_q;
    if (out_full_q && !out_stall_i) out_full_d = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH1;
        end
      end
      ST_HASH1: begin
        if (sts_i.is_alloc) begin
          cmd_o.hash1 = 1'b1;
          state_d     = ST_MUL;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_READ;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_HASH2;
      end
      ST_HASH2: begin
        cmd_o.hash2 = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the result register is free or drains this cycle
        if (!out_full_q || !out_stall_i) begin
          cmd_o.update = 1'b1;
          out_full_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/asp_datapath.sv =====
// ----------------------------------------------------------------------------
// asp_datapath: hash, site tables, global counters and result register
// Site tables live in one wide memory with a registered read port.
// ----------------------------------------------------------------------------
module asp_datapath import asp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  asp_cmd_t    cmd_i,
  output asp_sts_t    sts_o,
  input  asp_in_t     in_req_i,
  input  logic        peak_step_wr_en_i,
  input  logic [31:0] peak_step_wr_data_i,
  output asp_out_t    out_rsp_o
);

  localparam int unsigned EntW = 64 + 48 + 32 + 48 + 32;

  typedef struct packed {
    logic [63:0] addr;
    logic [47:0] bytes_live;
    logic [31:0] blocks_live;
    logic [47:0] bytes_ever;
    logic [31:0] allocs_ever;
  } entry_t;

  logic [EntW-1:0] mem_q [SiteCap];
  entry_t          rd_q;
  site_idx_t       slot_q;
  site_idx_t       clr_ptr_q;
  logic            clr_done_q;

  asp_in_t     req_q;
  logic [63:0] h_q;
  logic [63:0] pp_lo_q;
  logic [31:0] pp_x_q;
  logic [31:0] peak_step_q;
  logic [47:0] live_q, peak_q;
  logic [48:0] mark_q;
  logic [31:0] dumps_q, coll_q, foreign_q;
  asp_out_t    rsp_q;

  logic [63:0] h1, h2;
  logic [63:0] pp_lo;
  logic [31:0] cross_a, cross_b;
  site_idx_t   hslot;
  logic        wr_en;
  site_idx_t   wr_idx;
  entry_t      wr_ent;

  assign sts_o.clear_done = clr_done_q;
  assign sts_o.is_alloc   = (req_q.operation == OP_ALLOC);
  assign out_rsp_o        = rsp_q;

  assign h1    = req_q.return_addr ^ {33'd0, req_q.return_addr[63:33]};
  assign h2    = h_q ^ {29'd0, h_q[63:29]};
  assign hslot = (h2[SiteBits-1:0] == '0) ? site_idx_t'(1) : h2[SiteBits-1:0];

  // 64-bit product mod 2^64 from 32x32 pieces: low x low in full, the two
  // cross terms only in their low halves.
  assign pp_lo   = 64'(h1[31:0]) * 64'(HashMul[31:0]);
  assign cross_a = h1[63:32] * HashMul[31:0];
  assign cross_b = h1[31:0] * HashMul[63:32];

  // Clear pointer runs once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clear_step) begin
      clr_ptr_q <= clr_ptr_q + site_idx_t'(1);
      if (clr_ptr_q == site_idx_t'(SiteCap - 1)) clr_done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_step_q <= PeakStepReset;
    end else if (peak_step_wr_en_i) begin
      peak_step_q <= peak_step_wr_data_i;
    end
  end

  // Request capture, hash multiply and slot select.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.hash1) begin
      pp_lo_q <= pp_lo;
      pp_x_q  <= cross_a;
    end
    if (cmd_i.mul) h_q <= pp_lo_q + {pp_x_q + cross_b, 32'd0};
    if (cmd_i.hash2) slot_q <= hslot;
    else if (cmd_i.rd) slot_q <= req_q.header_slot[SiteBits-1:0];
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_idx] <= wr_ent;
    rd_q <= entry_t'(mem_q[slot_q]);
  end

  // Read-modify-write of the addressed entry and global counters.
  logic [47:0] live_n, peak_n;
  logic [48:0] mark_n;
  logic [31:0] dumps_n, coll_n, foreign_n;
  logic        dump_n, upd_tab;
  entry_t      ent_n;

  always_comb begin
    ent_n     = rd_q;
    live_n    = live_q;
    peak_n    = peak_q;
    mark_n    = mark_q;
    dumps_n   = dumps_q;
    coll_n    = coll_q;
    foreign_n = foreign_q;
    dump_n    = 1'b0;
    upd_tab   = 1'b0;
    unique case (op_e'(req_q.operation))
      OP_ALLOC: begin
        upd_tab = 1'b1;
        if (rd_q.addr != 64'd0 && rd_q.addr != req_q.return_addr) coll_n = inc32(coll_q);
        if (rd_q.addr == 64'd0 || rd_q.addr != req_q.return_addr)
          ent_n.addr = req_q.return_addr;
        ent_n.bytes_live  = add48(rd_q.bytes_live, req_q.block_size);
        ent_n.blocks_live = inc32(rd_q.blocks_live);
        ent_n.bytes_ever  = add48(rd_q.bytes_ever, req_q.block_size);
        ent_n.allocs_ever = inc32(rd_q.allocs_ever);
        live_n = add48(live_q, req_q.block_size);
        if (live_n > peak_q) peak_n = live_n;
        if ({1'b0, live_n} >= mark_q) begin
          mark_n  = {1'b0, live_n} + {17'd0, peak_step_q};
          dumps_n = inc32(dumps_q);
          dump_n  = 1'b1;
        end
      end
      OP_FREE: begin
        if (!req_q.header_valid) begin
          foreign_n = inc32(foreign_q);
        end else begin
          upd_tab          = 1'b1;
          ent_n.bytes_live = sub48(rd_q.bytes_live, req_q.block_size);
          if (rd_q.blocks_live != 32'd0) ent_n.blocks_live = rd_q.blocks_live - 32'd1;
          live_n = sub48(live_q, req_q.block_size);
        end
      end
      OP_READ, OP_READ3: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd_i.clear_step) begin
      wr_en  = 1'b1;
      wr_idx = clr_ptr_q;
      wr_ent = '0;
    end else begin
      wr_en  = cmd_i.update && upd_tab;
      wr_idx = slot_q;
      wr_ent = ent_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      peak_q    <= '0;
      mark_q    <= '0;
      dumps_q   <= '0;
      coll_q    <= '0;
      foreign_q <= '0;
    end else if (cmd_i.update) begin
      live_q    <= live_n;
      peak_q    <= peak_n;
      mark_q    <= mark_n;
      dumps_q   <= dumps_n;
      coll_q    <= coll_n;
      foreign_q <= foreign_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rsp_q.slot             <= 12'(slot_q);
      rsp_q.site_addr        <= ent_n.addr;
      rsp_q.site_live_bytes  <= ent_n.bytes_live;
      rsp_q.site_live_count  <= ent_n.blocks_live;
      rsp_q.site_total_bytes <= ent_n.bytes_ever;
      rsp_q.site_total_count <= ent_n.allocs_ever;
      rsp_q.live_total       <= live_n;
      rsp_q.peak_total       <= peak_n;
      rsp_q.dump_now         <= dump_n;
      rsp_q.dump_count       <= dumps_n;
      rsp_q.collision_count  <= coll_n;
      rsp_q.foreign_count    <= foreign_n;
    end
  end

endmodule
